/* rtl/skl_pkg.sv */
// skl_pkg: shared types and codes for the sorted key list
// no dependencies; imported by the interfaces, the cell and the top level
package skl_pkg;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE_MAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_KEY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                    cmp;
    logic                    ins;
    logic                    rmk;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } skl_ctl_t;

endpackage

/* rtl/skl_if.sv */
// skl_req_if / skl_rsp_if: valid-ready channels for commands and results
// depends on skl_pkg
interface skl_req_if
  import skl_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0]        payload;

  modport source (output valid, command, key, payload, input ready);
  modport sink (input valid, command, key, payload, output ready);
endinterface

interface skl_rsp_if
  import skl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink (input valid, status, entry_count, output ready);
endinterface

/* rtl/skl_cell.sv */
// skl_cell: one slot of the sorted chain, holds a key and its payload
// depends on skl_pkg; instantiated in a row by sorted_key_list
module skl_cell
  import skl_pkg::*;
(
  input  logic                    clk,
  input  skl_ctl_t                ctl,
  input  logic                    occ,
  input  logic                    left_less,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0]        left_payload,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic [PAY_W-1:0]        right_payload,
  output logic signed [KEY_W-1:0] key,
  output logic [PAY_W-1:0]        payload,
  output logic                    less,
  output logic                    eq
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      less <= occ && (key < ctl.key);
      eq   <= occ && (key == ctl.key);
    end
    if (ctl.ins && !less) begin
      // the first cell that is not less takes the new word, the rest shift right
      if (left_less) begin
        key     <= ctl.key;
        payload <= ctl.payload;
      end else begin
        key     <= left_key;
        payload <= left_payload;
      end
    end
    if (ctl.rmk && occ && !less) begin
      key     <= right_key;
      payload <= right_payload;
    end
  end

endmodule

/* rtl/sorted_key_list.sv */
// sorted_key_list: a row of CAPACITY cells holding records in ascending signed
// key order. A command is latched, then every cell compares its key against
// the broadcast key and registers the flags, then all cells shift at once;
// the shift is held while the output register still holds an untaken result.
// The next command is accepted once the result has moved to the output
// register. Insert puts a new key ahead of equal keys; remove-by-key drops the
// first match. Status is ok, full (insert only) or miss, with the entry count.
module sorted_key_list
  import skl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  skl_req_if.sink         req,
  skl_rsp_if.source       rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]              state;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] cmd_key;
  logic [PAY_W-1:0]        cmd_payload;
  logic [CW-1:0]           count;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic [COUNT_W-1:0]      out_count;

  logic signed [KEY_W-1:0] keys [CAPACITY];
  logic [PAY_W-1:0]        pays [CAPACITY];
  logic [CAPACITY-1:0]     less_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     occ_vec;

  skl_ctl_t           ctl;
  logic               upd_go;
  logic               full;
  logic               any_eq;
  logic [CW-1:0]      count_next;
  logic [STAT_W-1:0]  status_next;
  logic [CW+COUNT_W-1:0] count_ext;

  assign full   = (count == CAP_C);
  assign any_eq = |eq_vec;
  assign upd_go = (state == S_UPD) && (!out_valid || rsp.ready);

  assign ctl.cmp     = (state == S_CMP);
  assign ctl.ins     = upd_go && (cmd == CMD_INSERT) && !full;
  assign ctl.rmk     = upd_go && (cmd == CMD_REMOVE_KEY) && any_eq;
  assign ctl.key     = cmd_key;
  assign ctl.payload = cmd_payload;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic                    l_less;
      logic signed [KEY_W-1:0] l_key;
      logic [PAY_W-1:0]        l_pay;
      logic signed [KEY_W-1:0] r_key;
      logic [PAY_W-1:0]        r_pay;

      assign occ_vec[i] = (IDX < count);

      if (i == 0) begin : g_head
        assign l_less = 1'b1;
        assign l_key  = keys[0];
        assign l_pay  = pays[0];
      end else begin : g_mid
        assign l_less = less_vec[i-1];
        assign l_key  = keys[i-1];
        assign l_pay  = pays[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign r_key = keys[i];
        assign r_pay = pays[i];
      end else begin : g_body
        assign r_key = keys[i+1];
        assign r_pay = pays[i+1];
      end

      skl_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .occ          (occ_vec[i]),
        .left_less    (l_less),
        .left_key     (l_key),
        .left_payload (l_pay),
        .right_key    (r_key),
        .right_payload(r_pay),
        .key          (keys[i]),
        .payload      (pays[i]),
        .less         (less_vec[i]),
        .eq           (eq_vec[i])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = STAT_MISS;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          status_next = STAT_OK;
          count_next  = count + 1'b1;
        end
      end
      CMD_REMOVE_MAX: begin
        if (count != '0) begin
          status_next = STAT_OK;
          count_next  = count - 1'b1;
        end
      end
      CMD_REMOVE_KEY: begin
        if (any_eq) begin
          status_next = STAT_OK;
          count_next  = count - 1'b1;
        end
      end
      default: begin
        status_next = STAT_MISS;
      end
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            state     <= S_IDLE;
            count     <= count_next;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd         <= req.command;
      cmd_key     <= req.key;
      cmd_payload <= req.payload;
    end
    if (upd_go) begin
      out_status <= status_next;
      out_count  <= count_ext[COUNT_W-1:0];
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_CMP)
    else $error("accepted word did not enter compare");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_rsp_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_UPD)
    else $error("result raised outside update");

  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.rmk))
    else $error("insert and removal shift together");

endmodule

/* tb/skl_checker.sv */
// skl_checker: watches the command and result channels of sorted_key_list,
// keeps its own sorted list, predicts each result word and compares it
// depends on skl_pkg, skl_req_if and skl_rsp_if
module skl_checker
  import skl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  skl_req_if   req,
  skl_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   full_seen,
  output int   miss_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_word_t;

  logic signed [KEY_W-1:0] list_key [CAPACITY];
  logic [PAY_W-1:0]        list_pay [CAPACITY];
  int                      list_fill;
  rsp_word_t               expected_rsp_q [$];

  // applies one command to the shadow list and returns the word it should give
  function automatic rsp_word_t run_command(input logic [CMD_W-1:0] cmd,
                                            input logic signed [KEY_W-1:0] key,
                                            input logic [PAY_W-1:0] pay);
    rsp_word_t w;
    int pos;
    int i;
    w.status = STAT_MISS;
    case (cmd)
      CMD_INSERT: begin
        if (list_fill >= CAPACITY) begin
          w.status = STAT_FULL;
        end else begin
          // stop at the first key that is not less, so equal keys end up behind
          pos = 0;
          while (pos < list_fill && list_key[pos] < key) pos++;
          for (i = list_fill; i > pos; i--) begin
            list_key[i] = list_key[i-1];
            list_pay[i] = list_pay[i-1];
          end
          list_key[pos] = key;
          list_pay[pos] = pay;
          list_fill++;
          w.status = STAT_OK;
        end
      end
      CMD_REMOVE_MAX: begin
        if (list_fill > 0) begin
          list_fill--;
          w.status = STAT_OK;
        end
      end
      CMD_REMOVE_KEY: begin
        pos = 0;
        while (pos < list_fill && list_key[pos] != key) pos++;
        if (pos < list_fill) begin
          for (i = pos; i + 1 < list_fill; i++) begin
            list_key[i] = list_key[i+1];
            list_pay[i] = list_pay[i+1];
          end
          list_fill--;
          w.status = STAT_OK;
        end
      end
      default: ;
    endcase
    w.entry_count = COUNT_W'(list_fill);
    return w;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    rsp_word_t want;
    if (rst) begin
      list_fill = 0;
      expected_rsp_q.delete();
    end else begin
      // results first, so a word in the same cycle as a new command pairs with older ones
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          flag_error($sformatf("result word with none expected: status %0d count %0d",
                               rsp.status, rsp.entry_count));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status)
            flag_error($sformatf("status expected %0d got %0d", want.status, rsp.status));
          if (rsp.entry_count !== want.entry_count)
            flag_error($sformatf("entry_count expected %0d got %0d",
                                 want.entry_count, rsp.entry_count));
        end
      end
      if (req.valid && req.ready) begin
        want = run_command(req.command, req.key, req.payload);
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_MISS) miss_seen++;
        expected_rsp_q.push_back(want);
      end
    end
    pending = expected_rsp_q.size();
  end

endmodule

/* tb/tb_sorted_key_list.sv */
// tb_sorted_key_list: clock, reset and command stimulus for sorted_key_list,
// random stalls on both channels and the final verdict
// depends on skl_pkg, the channel interfaces, skl_checker and the block itself
module tb_sorted_key_list
  import skl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_WORDS = 1250;
  localparam int IDLE_PCT     = 10;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 900;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 200000;

  localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN    = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX    = {1'b0, {(KEY_W-1){1'b1}}};

  logic clk;
  logic rst;
  int   words_sent;
  bit   quiet;
  int   cycle_count;
  int   fail_count;
  int   pending;
  int   full_seen;
  int   miss_seen;

  skl_req_if req ();
  skl_rsp_if rsp ();

  sorted_key_list #(.CAPACITY(CAPACITY)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  skl_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .full_seen  (full_seen),
    .miss_seen  (miss_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly a small key pool so removals hit and duplicates occur
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(8) - 4;
    else if (r < 70) return KEY_MIN;
    else if (r < 80) return KEY_MAX;
    else return $urandom();
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct) return CMD_INSERT;
    r = $urandom_range(99);
    if (r < 45) return CMD_REMOVE_MAX;
    else if (r < 95) return CMD_REMOVE_KEY;
    else return CMD_UNUSED;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic signed [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.key     <= key;
    req.payload <= pay;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
  endtask

  // result side: random stalls plus one long hold-off that backs up the input
  initial begin : result_side
    bit held;
    held = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : command_side
    int n;
    int insert_pct;
    rst         = 1'b1;
    quiet       = 1'b0;
    words_sent  = 0;
    insert_pct  = 50;
    req.valid   = 1'b0;
    req.command = CMD_INSERT;
    req.key     = '0;
    req.payload = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list and the unused code
    send_word(CMD_REMOVE_MAX, 0, 8'h00);
    send_word(CMD_REMOVE_KEY, 5, 8'h00);
    send_word(CMD_UNUSED, KEY_MAX, 8'hff);
    // key extremes and a duplicate key
    send_word(CMD_INSERT, KEY_MAX, 8'hff);
    send_word(CMD_INSERT, KEY_MIN, 8'h00);
    send_word(CMD_INSERT, 0, 8'h11);
    send_word(CMD_INSERT, 0, 8'h22);
    send_word(CMD_INSERT, -1, 8'h33);
    send_word(CMD_REMOVE_KEY, 0, 8'h00);
    send_word(CMD_REMOVE_KEY, 12345, 8'h00);
    send_word(CMD_REMOVE_MAX, 0, 8'h00);
    // three entries left; fill up, then one insert into a full list
    for (n = 3; n < CAPACITY; n++) send_word(CMD_INSERT, n * n - 40, PAY_W'(n));
    send_word(CMD_INSERT, 7, 8'h5a);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // rotate between filling, balanced and draining phases
      if (n % 50 == 0) begin
        case ((n / 50) % 3)
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
      end
      quiet = (n >= QUIET_FROM && n < QUIET_TO);
      send_word(pick_command(insert_pct), pick_key(), PAY_W'($urandom_range(255)));
    end
    quiet = 1'b0;
    @(negedge clk);
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run summary: %0d command words, %0d inserts rejected on a full list,",
             words_sent, full_seen);
    $display("  %0d empty or unmatched commands, one result hold-off of %0d cycles",
             miss_seen, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
